/* rtl/tofdpc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tofdpc_pkg
// Shared constants, widths and the remainder table for the time-of-flight
// distance phase correction pipeline.
// ----------------------------------------------------------------------------
package tofdpc_pkg;

    // fixed-point fraction bits of all intermediate values
    localparam int FRAC_BITS = 24;

    localparam int RAW_W = 16;
    localparam int MM_W  = 12;

    // raw word is in 0.5 mm units: meters = raw / 2000 = raw / (16 * 125)
    localparam int RAW_POW2_SHIFT = 4;
    localparam int DIV_BY         = 125;

    // raw / 125 by reciprocal multiply, exact for every 16-bit raw word
    localparam int DIV_SHIFT = 24;
    localparam int DIV_MUL_W = 18;
    localparam logic [DIV_MUL_W-1:0] DIV_MUL =
        DIV_MUL_W'(((64'd1 << DIV_SHIFT) + 64'(DIV_BY) - 64'd1) / 64'(DIV_BY));
    localparam int DIV_PROD_W = RAW_W + DIV_MUL_W;
    localparam int Q_W        = 10;
    localparam int REM_W      = 7;
    localparam int REM_DEPTH  = 1 << REM_W;

    // fraction part of d that comes from the remainder
    localparam int DFRAC_W = FRAC_BITS - RAW_POW2_SHIFT;

    // phase scale: round(pi * 2^(F+16) / 33300)
    localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
    localparam int KP_W = FRAC_BITS + 4;
    localparam logic [KP_W-1:0] KP =
        KP_W'(((PI_Q60 >> (44 - FRAC_BITS)) + 64'd16650) / 64'd33300);
    localparam int KP_SHIFT  = 16;
    localparam int PHASE_PROD_W = RAW_W + KP_W;

    // value widths (magnitudes unless noted)
    localparam int P_W    = FRAC_BITS + 3;   // phase, below 8
    localparam int D_W    = Q_W + DFRAC_W;   // uncorrected distance, below 64
    localparam int COEF_W = FRAC_BITS + 2;   // coefficients, below 4
    localparam int M0_W   = FRAC_BITS + 3;   // c3 * p
    localparam int T1_W   = FRAC_BITS + 3;   // first Horner term
    localparam int M1_W   = FRAC_BITS + 5;   // t1 * p
    localparam int T2_W   = FRAC_BITS + 6;   // second Horner term
    localparam int M2_W   = FRAC_BITS + 9;   // t2 * p
    localparam int T3_W   = FRAC_BITS + 10;  // correction, two's complement
    localparam int DIST_W = FRAC_BITS + 11;  // corrected distance, two's complement

    localparam int MM_SCALE_W = 10;
    localparam logic [MM_SCALE_W-1:0] MM_SCALE = MM_SCALE_W'(1000);
    localparam int MM_PROD_W = FRAC_BITS + 2 + MM_SCALE_W;

    // cubic coefficients, rounded to nearest in QF
    localparam logic [COEF_W-1:0] C3 =
        COEF_W'(((64'd11637 << FRAC_BITS) + 64'd5000) / 64'd10000);
    localparam logic [COEF_W-1:0] C2 =
        COEF_W'(((64'd38654 << FRAC_BITS) + 64'd5000) / 64'd10000);
    localparam logic [COEF_W-1:0] C1 =
        COEF_W'(((64'd13796 << FRAC_BITS) + 64'd5000) / 64'd10000);
    localparam logic [COEF_W-1:0] C0 =
        COEF_W'(((64'd436 << FRAC_BITS) + 64'd5000) / 64'd10000);

    // three meters in QF
    localparam logic [DIST_W-2:0] THREE_M = (DIST_W-1)'(64'd3 << FRAC_BITS);

    // register ranks ahead of the output register
    localparam int NUM_STAGES = 7;

    typedef logic [DFRAC_W-1:0] dfrac_t;
    typedef dfrac_t dfrac_tbl_t [REM_DEPTH];

    // floor(rem * 2^(F-4) / 125) for every remainder of raw / 125
    function automatic dfrac_tbl_t build_dfrac_tbl();
        dfrac_tbl_t tbl;
        for (int i = 0; i < REM_DEPTH; i++)
        begin
            if (i < DIV_BY)
            begin
                tbl[i] = DFRAC_W'((64'(i) << DFRAC_W) / 64'(DIV_BY));
            end
            else
            begin
                tbl[i] = '0;
            end
        end
        return tbl;
    endfunction

    localparam dfrac_tbl_t DFRAC_TBL = build_dfrac_tbl();

endpackage

/* rtl/tof_distance_phase_correction.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tof_distance_phase_correction
// Converts raw time-of-flight distance words to millimeters with a cubic
// phase-error correction, fully pipelined.
// ----------------------------------------------------------------------------
// usage
//   input channel: raw_distance is taken at a rising edge where start is high
//   and busy is low. busy is always low, so a new word can be transferred in
//   every cycle, back to back.
//   output channel: done is high for exactly one cycle while distance_mm and
//   out_of_range hold the result; the receiver takes it at the edge that ends
//   that cycle and cannot hold it off.
//   pipeline: the accepting edge loads the first rank; six more ranks and the
//   output register follow, and done rises when the result reaches the output
//   register. throughput is one item per cycle; the depth is set by the chain
//   of three dependent multiplies of the Horner evaluation: the first shares
//   its rank with its add, the other two are each followed by their own add rank.
//   results come out in transfer order, one per input.
//   reset: rst_n clears the valid chain and done; nothing is in flight after
//   reset and no clearing pass is needed.
//   out-of-range: a corrected distance above 3 m gives distance_mm = 0 with
//   out_of_range set; a negative one gives 0 with the flag clear.
// ----------------------------------------------------------------------------
module tof_distance_phase_correction
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [tofdpc_pkg::RAW_W-1:0]  raw_distance,
    output logic                          done,
    output logic [tofdpc_pkg::MM_W-1:0]   distance_mm,
    output logic                          out_of_range
);

    // valid chain, one bit per pipeline rank
    logic [tofdpc_pkg::NUM_STAGES-1:0] valid_reg;
    logic [tofdpc_pkg::NUM_STAGES-1:0] valid_next;
    logic                              done_reg;

    // stage 1: reciprocal divide by 125 and phase scaling
    logic [tofdpc_pkg::DIV_PROD_W-1:0]   div_prod;
    logic [tofdpc_pkg::PHASE_PROD_W-1:0] phase_prod;
    logic [tofdpc_pkg::RAW_W-1:0]        s1_raw_reg;
    logic [tofdpc_pkg::Q_W-1:0]          s1_q_reg;
    logic [tofdpc_pkg::Q_W-1:0]          s1_q_next;
    logic [tofdpc_pkg::P_W-1:0]          s1_p_reg;
    logic [tofdpc_pkg::P_W-1:0]          s1_p_next;

    // stage 2: meters from quotient and remainder, c3 * p - c2
    logic [tofdpc_pkg::RAW_W-1:0]          q_times_div;
    logic [tofdpc_pkg::RAW_W-1:0]          rem_full;
    logic [tofdpc_pkg::COEF_W+tofdpc_pkg::P_W-1:0] m0_prod;
    logic [tofdpc_pkg::M0_W-1:0]           m0;
    logic [tofdpc_pkg::D_W-1:0]            s2_d_reg;
    logic [tofdpc_pkg::D_W-1:0]            s2_d_next;
    logic [tofdpc_pkg::P_W-1:0]            s2_p_reg;
    logic [tofdpc_pkg::T1_W-1:0]           s2_t1_reg;
    logic [tofdpc_pkg::T1_W-1:0]           s2_t1_next;
    logic                                  s2_neg_reg;
    logic                                  s2_neg_next;

    // stage 3: |t1| * p
    logic [tofdpc_pkg::T1_W+tofdpc_pkg::P_W-1:0] m1_prod;
    logic [tofdpc_pkg::D_W-1:0]            s3_d_reg;
    logic [tofdpc_pkg::P_W-1:0]            s3_p_reg;
    logic [tofdpc_pkg::M1_W-1:0]           s3_m1_reg;
    logic [tofdpc_pkg::M1_W-1:0]           s3_m1_next;
    logic                                  s3_neg_reg;

    // stage 4: t2 = +-m1 + c1, kept as sign and magnitude
    logic [tofdpc_pkg::D_W-1:0]            s4_d_reg;
    logic [tofdpc_pkg::P_W-1:0]            s4_p_reg;
    logic [tofdpc_pkg::T2_W-1:0]           s4_t2_reg;
    logic [tofdpc_pkg::T2_W-1:0]           s4_t2_next;
    logic                                  s4_neg_reg;
    logic                                  s4_neg_next;

    // stage 5: |t2| * p
    logic [tofdpc_pkg::T2_W+tofdpc_pkg::P_W-1:0] m2_prod;
    logic [tofdpc_pkg::D_W-1:0]            s5_d_reg;
    logic [tofdpc_pkg::M2_W-1:0]           s5_m2_reg;
    logic [tofdpc_pkg::M2_W-1:0]           s5_m2_next;
    logic                                  s5_neg_reg;

    // stage 6: t3 = +-m2 - c0, two's complement
    logic [tofdpc_pkg::T3_W-1:0]           m2_signed;
    logic [tofdpc_pkg::D_W-1:0]            s6_d_reg;
    logic [tofdpc_pkg::T3_W-1:0]           s6_t3_reg;
    logic [tofdpc_pkg::T3_W-1:0]           s6_t3_next;

    // stage 7: corrected distance
    logic [tofdpc_pkg::DIST_W-1:0]         s7_dist_reg;
    logic [tofdpc_pkg::DIST_W-1:0]         s7_dist_next;

    // output stage: range check and conversion to mm
    logic [tofdpc_pkg::MM_PROD_W-1:0]      mm_prod;
    logic                                  too_far;
    logic                                  positive;
    logic [tofdpc_pkg::MM_W-1:0]           distance_mm_reg;
    logic [tofdpc_pkg::MM_W-1:0]           distance_mm_next;
    logic                                  out_of_range_reg;
    logic                                  out_of_range_next;

    // no back-pressure anywhere: a transfer is taken every cycle
    assign busy = 1'b0;

    assign valid_next = {valid_reg[tofdpc_pkg::NUM_STAGES-2:0], start & ~busy};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            done_reg  <= valid_reg[tofdpc_pkg::NUM_STAGES-1];
        end
    end

    // ---------------- stage 1 ----------------
    assign div_prod = tofdpc_pkg::DIV_PROD_W'(raw_distance)
                    * tofdpc_pkg::DIV_PROD_W'(tofdpc_pkg::DIV_MUL);
    assign s1_q_next = div_prod[tofdpc_pkg::DIV_SHIFT +: tofdpc_pkg::Q_W];

    // p = floor(raw * KP / 2^16)
    assign phase_prod = tofdpc_pkg::PHASE_PROD_W'(raw_distance)
                      * tofdpc_pkg::PHASE_PROD_W'(tofdpc_pkg::KP);
    assign s1_p_next = phase_prod[tofdpc_pkg::KP_SHIFT +: tofdpc_pkg::P_W];

    // ---------------- stage 2 ----------------
    // remainder of raw / 125 picks the fraction part of d
    assign q_times_div = tofdpc_pkg::RAW_W'(s1_q_reg)
                       * tofdpc_pkg::RAW_W'(tofdpc_pkg::DIV_BY);
    assign rem_full    = s1_raw_reg - q_times_div;
    assign s2_d_next   = {s1_q_reg, tofdpc_pkg::DFRAC_TBL[rem_full[tofdpc_pkg::REM_W-1:0]]};

    assign m0_prod = (tofdpc_pkg::COEF_W + tofdpc_pkg::P_W)'(s1_p_reg)
                   * (tofdpc_pkg::COEF_W + tofdpc_pkg::P_W)'(tofdpc_pkg::C3);
    assign m0      = m0_prod[tofdpc_pkg::FRAC_BITS +: tofdpc_pkg::M0_W];

    // t1 = c3 * p - c2 as sign and magnitude
    always_comb
    begin
        if (m0 >= tofdpc_pkg::M0_W'(tofdpc_pkg::C2))
        begin
            s2_neg_next = 1'b0;
            s2_t1_next  = tofdpc_pkg::T1_W'(m0 - tofdpc_pkg::M0_W'(tofdpc_pkg::C2));
        end
        else
        begin
            s2_neg_next = 1'b1;
            s2_t1_next  = tofdpc_pkg::T1_W'(tofdpc_pkg::M0_W'(tofdpc_pkg::C2) - m0);
        end
    end

    // ---------------- stage 3 ----------------
    // magnitude product truncated toward zero
    assign m1_prod = (tofdpc_pkg::T1_W + tofdpc_pkg::P_W)'(s2_t1_reg)
                   * (tofdpc_pkg::T1_W + tofdpc_pkg::P_W)'(s2_p_reg);
    assign s3_m1_next = m1_prod[tofdpc_pkg::FRAC_BITS +: tofdpc_pkg::M1_W];

    // ---------------- stage 4 ----------------
    always_comb
    begin
        if (!s3_neg_reg)
        begin
            s4_neg_next = 1'b0;
            s4_t2_next  = tofdpc_pkg::T2_W'(s3_m1_reg) + tofdpc_pkg::T2_W'(tofdpc_pkg::C1);
        end
        else if (s3_m1_reg > tofdpc_pkg::M1_W'(tofdpc_pkg::C1))
        begin
            s4_neg_next = 1'b1;
            s4_t2_next  = tofdpc_pkg::T2_W'(s3_m1_reg - tofdpc_pkg::M1_W'(tofdpc_pkg::C1));
        end
        else
        begin
            s4_neg_next = 1'b0;
            s4_t2_next  = tofdpc_pkg::T2_W'(tofdpc_pkg::M1_W'(tofdpc_pkg::C1) - s3_m1_reg);
        end
    end

    // ---------------- stage 5 ----------------
    assign m2_prod = (tofdpc_pkg::T2_W + tofdpc_pkg::P_W)'(s4_t2_reg)
                   * (tofdpc_pkg::T2_W + tofdpc_pkg::P_W)'(s4_p_reg);
    assign s5_m2_next = m2_prod[tofdpc_pkg::FRAC_BITS +: tofdpc_pkg::M2_W];

    // ---------------- stage 6 ----------------
    assign m2_signed  = s5_neg_reg ? (tofdpc_pkg::T3_W'(0) - tofdpc_pkg::T3_W'(s5_m2_reg))
                                   : tofdpc_pkg::T3_W'(s5_m2_reg);
    assign s6_t3_next = m2_signed - tofdpc_pkg::T3_W'(tofdpc_pkg::C0);

    // ---------------- stage 7 ----------------
    assign s7_dist_next = tofdpc_pkg::DIST_W'(s6_d_reg)
                        + {{(tofdpc_pkg::DIST_W - tofdpc_pkg::T3_W){s6_t3_reg[tofdpc_pkg::T3_W-1]}},
                           s6_t3_reg};

    // ---------------- output stage ----------------
    assign too_far  = !s7_dist_reg[tofdpc_pkg::DIST_W-1]
                    && (s7_dist_reg[tofdpc_pkg::DIST_W-2:0] > tofdpc_pkg::THREE_M);
    assign positive = !s7_dist_reg[tofdpc_pkg::DIST_W-1] && (s7_dist_reg != '0);

    // within range the distance is at most 3.0, so F+2 bits carry it
    assign mm_prod = tofdpc_pkg::MM_PROD_W'(s7_dist_reg[tofdpc_pkg::FRAC_BITS+1:0])
                   * tofdpc_pkg::MM_PROD_W'(tofdpc_pkg::MM_SCALE);

    always_comb
    begin
        distance_mm_next  = '0;
        out_of_range_next = 1'b0;
        if (too_far)
        begin
            out_of_range_next = 1'b1;
        end
        else if (positive)
        begin
            distance_mm_next = mm_prod[tofdpc_pkg::FRAC_BITS +: tofdpc_pkg::MM_W];
        end
    end

    // payload ranks, no reset needed
    always_ff @(posedge clk)
    begin
        s1_raw_reg       <= raw_distance;
        s1_q_reg         <= s1_q_next;
        s1_p_reg         <= s1_p_next;

        s2_d_reg         <= s2_d_next;
        s2_p_reg         <= s1_p_reg;
        s2_t1_reg        <= s2_t1_next;
        s2_neg_reg       <= s2_neg_next;

        s3_d_reg         <= s2_d_reg;
        s3_p_reg         <= s2_p_reg;
        s3_m1_reg        <= s3_m1_next;
        s3_neg_reg       <= s2_neg_reg;

        s4_d_reg         <= s3_d_reg;
        s4_p_reg         <= s3_p_reg;
        s4_t2_reg        <= s4_t2_next;
        s4_neg_reg       <= s4_neg_next;

        s5_d_reg         <= s4_d_reg;
        s5_m2_reg        <= s5_m2_next;
        s5_neg_reg       <= s4_neg_reg;

        s6_d_reg         <= s5_d_reg;
        s6_t3_reg        <= s6_t3_next;

        s7_dist_reg      <= s7_dist_next;

        distance_mm_reg  <= distance_mm_next;
        out_of_range_reg <= out_of_range_next;
    end

    assign done         = done_reg;
    assign distance_mm  = distance_mm_reg;
    assign out_of_range = out_of_range_reg;

endmodule
